>>> rtl/kruskal_min_spanning_tree_top_macros.svh
// ----------------------------------------------------------------------------
// Kruskal MST assertion macros
// Shared concurrent assertion forms for the spanning tree block.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_MIN_SPANNING_TREE_TOP_MACROS_SVH
`define KRUSKAL_MIN_SPANNING_TREE_TOP_MACROS_SVH

// same-cycle implication
`define KMST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kmst assertion failed");

// next-cycle implication
`define KMST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kmst assertion failed");

`endif

>>> rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// Kruskal MST package
// Types and constants shared by the spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int VTX_BITS     = 4;
    localparam int EDGE_AW      = 8;
    localparam int COST_BITS    = 20;
    localparam int NV_BITS      = 5;

    localparam logic RESULT_EDGE    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef struct packed {
        logic [VTX_BITS-1:0]    cell_row;
        logic [VTX_BITS-1:0]    cell_col;
        logic [WEIGHT_BITS-1:0] cell_weight;
        logic                   cell_present;
        logic                   last_cell;
    } t_cell_req;

    typedef struct packed {
        logic                   result_kind;
        logic [VTX_BITS-1:0]    tree_from;
        logic [VTX_BITS-1:0]    tree_to;
        logic [WEIGHT_BITS-1:0] tree_weight;
        logic [COST_BITS-1:0]   total_cost;
        logic                   connected;
        logic                   is_last;
    } t_result;

    typedef struct packed {
        logic [VTX_BITS-1:0]    from_vtx;
        logic [VTX_BITS-1:0]    to_vtx;
        logic [WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic                clear;
        logic                find_start;
        logic [VTX_BITS-1:0] find_vtx;
        logic                link_en;
        logic [VTX_BITS-1:0] link_from;
        logic [VTX_BITS-1:0] link_to;
    } t_uf_cmd;

    typedef struct packed {
        logic                done;
        logic [VTX_BITS-1:0] root;
    } t_uf_sts;

endpackage

>>> rtl/kmst_ram.sv
// ----------------------------------------------------------------------------
// Kruskal MST generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kmst_uf.sv
// ----------------------------------------------------------------------------
// Kruskal MST union-find unit
// Parent links with root flags and a walker that finds a root one hop a cycle.
// ----------------------------------------------------------------------------
module kmst_uf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmst_pkg::t_uf_cmd i_cmd,
    output kmst_pkg::t_uf_sts o_sts
);

    logic [kmst_pkg::VTX_BITS-1:0]     r_parent [kmst_pkg::MAX_VERTICES];
    logic [kmst_pkg::MAX_VERTICES-1:0] r_nonroot;
    logic [kmst_pkg::VTX_BITS-1:0]     r_cur;
    logic                              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonroot <= '0;
            r_busy    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_nonroot <= '0;
            end else if (i_cmd.link_en) begin
                r_nonroot[i_cmd.link_from] <= 1'b1;
            end
            if (i_cmd.find_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !r_nonroot[r_cur]) begin
                r_busy <= 1'b0;
            end
        end
        if (i_cmd.link_en) begin
            r_parent[i_cmd.link_from] <= i_cmd.link_to;
        end
        if (i_cmd.find_start) begin
            r_cur <= i_cmd.find_vtx;
        end else if (r_busy && r_nonroot[r_cur]) begin
            r_cur <= r_parent[r_cur];
        end
    end

    assign o_sts.done = r_busy && !r_nonroot[r_cur];
    assign o_sts.root = r_cur;

endmodule

>>> rtl/kruskal_min_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// Kruskal MST top level
// Loads matrix cells, orders edges by weight and builds the spanning tree.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle while loading. After the last cell the
// request port stays low until the summary is taken. Edges are picked in
// stable weight order by repeated passes over the edge RAM through its one
// read port, one pass per edge considered, and each picked edge then walks
// the union-find links from both endpoints to their roots.
module kruskal_min_spanning_tree_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  kmst_pkg::t_cell_req                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output kmst_pkg::t_result                    o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [kmst_pkg::NV_BITS-1:0]         i_cfg_data
);

    localparam int KEY_BITS = kmst_pkg::WEIGHT_BITS + kmst_pkg::EDGE_AW;
    localparam int CNT_BITS = kmst_pkg::EDGE_AW + 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FIND_A,
        ST_FIND_B,
        ST_EMIT,
        ST_SUMMARY
    } t_state;

    t_state                          r_state, n_state;
    logic [kmst_pkg::NV_BITS-1:0]    r_cfg_nv;
    logic [kmst_pkg::NV_BITS-1:0]    r_nv, n_nv;
    logic [CNT_BITS-1:0]             r_count, n_count;
    logic [CNT_BITS-1:0]             r_addr, n_addr;
    logic                            r_rd_pend, n_rd_pend;
    logic [kmst_pkg::EDGE_AW-1:0]    r_rd_idx, n_rd_idx;
    logic                            r_have_prev, n_have_prev;
    logic [KEY_BITS-1:0]             r_prev_key, n_prev_key;
    logic                            r_best_found, n_best_found;
    logic [KEY_BITS-1:0]             r_best_key, n_best_key;
    logic [kmst_pkg::VTX_BITS-1:0]   r_best_from, n_best_from;
    logic [kmst_pkg::VTX_BITS-1:0]   r_best_to, n_best_to;
    logic [kmst_pkg::VTX_BITS-1:0]   r_ra, n_ra;
    logic [kmst_pkg::COST_BITS-1:0]  r_cost, n_cost;
    logic [kmst_pkg::VTX_BITS-1:0]   r_found, n_found;
    logic                            r_out_valid, n_out_valid;
    kmst_pkg::t_result               r_out, n_out;

    logic [kmst_pkg::NV_BITS-1:0]    eff_nv;
    logic                            in_accept;
    logic                            out_accept;
    logic                            keep_cell;
    logic                            ram_we;
    kmst_pkg::t_edge                 ram_wdata;
    kmst_pkg::t_edge                 ram_rdata;
    logic [KEY_BITS-1:0]             cand_key;
    logic                            cand_ok;
    logic [kmst_pkg::NV_BITS-1:0]    need;
    kmst_pkg::t_uf_cmd               uf_cmd;
    kmst_pkg::t_uf_sts               uf_sts;

    always_comb begin
        eff_nv = r_cfg_nv;
        if (r_cfg_nv < kmst_pkg::NV_BITS'(2)) begin
            eff_nv = kmst_pkg::NV_BITS'(2);
        end else if (r_cfg_nv > kmst_pkg::NV_BITS'(kmst_pkg::MAX_VERTICES)) begin
            eff_nv = kmst_pkg::NV_BITS'(kmst_pkg::MAX_VERTICES);
        end
    end

    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = r_out_valid && i_out_ready;
    assign keep_cell  = i_in_data.cell_present
                     && ({1'b0, i_in_data.cell_row} < eff_nv)
                     && ({1'b0, i_in_data.cell_col} < eff_nv)
                     && (r_count < CNT_BITS'(kmst_pkg::MAX_EDGES));
    assign ram_we     = in_accept && keep_cell;
    assign ram_wdata  = '{from_vtx: i_in_data.cell_row, to_vtx: i_in_data.cell_col,
                          weight: i_in_data.cell_weight};
    assign cand_key   = {ram_rdata.weight, r_rd_idx};
    assign cand_ok    = (!r_have_prev || (cand_key > r_prev_key))
                     && (!r_best_found || (cand_key < r_best_key));
    assign need       = r_nv - kmst_pkg::NV_BITS'(1);

    kmst_ram #(
        .WIDTH($bits(kmst_pkg::t_edge)),
        .DEPTH(kmst_pkg::MAX_EDGES)
    ) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[kmst_pkg::EDGE_AW-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr[kmst_pkg::EDGE_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    kmst_uf u_uf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (uf_cmd),
        .o_sts  (uf_sts)
    );

    always_comb begin
        n_state      = r_state;
        n_nv         = r_nv;
        n_count      = r_count;
        n_addr       = r_addr;
        n_rd_pend    = r_rd_pend;
        n_rd_idx     = r_rd_idx;
        n_have_prev  = r_have_prev;
        n_prev_key   = r_prev_key;
        n_best_found = r_best_found;
        n_best_key   = r_best_key;
        n_best_from  = r_best_from;
        n_best_to    = r_best_to;
        n_ra         = r_ra;
        n_cost       = r_cost;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        uf_cmd       = '0;

        case (r_state)
            ST_LOAD: begin
                if (in_accept) begin
                    if (keep_cell) begin
                        n_count = r_count + CNT_BITS'(1);
                    end
                    if (i_in_data.last_cell) begin
                        n_nv         = eff_nv;
                        n_have_prev  = 1'b0;
                        n_addr       = '0;
                        n_rd_pend    = 1'b0;
                        n_best_found = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_pend && cand_ok) begin
                    n_best_found = 1'b1;
                    n_best_key   = cand_key;
                    n_best_from  = ram_rdata.from_vtx;
                    n_best_to    = ram_rdata.to_vtx;
                end
                if (r_addr < r_count) begin
                    n_addr    = r_addr + CNT_BITS'(1);
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[kmst_pkg::EDGE_AW-1:0];
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        if (r_best_found) begin
                            n_have_prev       = 1'b1;
                            n_prev_key        = r_best_key;
                            uf_cmd.find_start = 1'b1;
                            uf_cmd.find_vtx   = r_best_from;
                            n_state           = ST_FIND_A;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out       = '{result_kind: kmst_pkg::RESULT_SUMMARY,
                                            tree_from: '0, tree_to: '0, tree_weight: '0,
                                            total_cost: r_cost,
                                            connected: ({1'b0, r_found} == need),
                                            is_last: 1'b1};
                            n_state     = ST_SUMMARY;
                        end
                    end
                end
            end
            ST_FIND_A: begin
                if (uf_sts.done) begin
                    n_ra              = uf_sts.root;
                    uf_cmd.find_start = 1'b1;
                    uf_cmd.find_vtx   = r_best_to;
                    n_state           = ST_FIND_B;
                end
            end
            ST_FIND_B: begin
                if (uf_sts.done) begin
                    n_addr       = '0;
                    n_rd_pend    = 1'b0;
                    n_best_found = 1'b0;
                    if (r_ra != uf_sts.root) begin
                        uf_cmd.link_en   = 1'b1;
                        uf_cmd.link_from = r_ra;
                        uf_cmd.link_to   = uf_sts.root;
                        n_cost  = r_cost + kmst_pkg::COST_BITS'(
                                  r_best_key[KEY_BITS-1:kmst_pkg::EDGE_AW]);
                        n_found = r_found + kmst_pkg::VTX_BITS'(1);
                        n_out_valid = 1'b1;
                        n_out   = '{result_kind: kmst_pkg::RESULT_EDGE,
                                    tree_from: r_best_from, tree_to: r_best_to,
                                    tree_weight: r_best_key[KEY_BITS-1:kmst_pkg::EDGE_AW],
                                    total_cost: '0, connected: 1'b0, is_last: 1'b0};
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_EMIT: begin
                if (out_accept) begin
                    if ({1'b0, r_found} == need) begin
                        n_out   = '{result_kind: kmst_pkg::RESULT_SUMMARY,
                                    tree_from: '0, tree_to: '0, tree_weight: '0,
                                    total_cost: r_cost, connected: 1'b1, is_last: 1'b1};
                        n_state = ST_SUMMARY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SUMMARY: begin
                if (out_accept) begin
                    n_out_valid  = 1'b0;
                    n_count      = '0;
                    n_cost       = '0;
                    n_found      = '0;
                    uf_cmd.clear = 1'b1;
                    n_state      = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cfg_nv    <= kmst_pkg::NV_BITS'(4);
            r_count     <= '0;
            r_cost      <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cfg_nv <= i_cfg_data;
            end
            r_count     <= n_count;
            r_cost      <= n_cost;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
        end
        r_nv         <= n_nv;
        r_addr       <= n_addr;
        r_rd_idx     <= n_rd_idx;
        r_have_prev  <= n_have_prev;
        r_prev_key   <= n_prev_key;
        r_best_found <= n_best_found;
        r_best_key   <= n_best_key;
        r_best_from  <= n_best_from;
        r_best_to    <= n_best_to;
        r_ra         <= n_ra;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "kruskal_min_spanning_tree_top_macros.svh"

    `KMST_ASSERT_NOW(a_no_overlap, o_out_valid, !o_in_ready)
    `KMST_ASSERT_NOW(a_summary_last, o_out_valid && o_out_data.result_kind, o_out_data.is_last)
    `KMST_ASSERT_NOW(a_found_bound, r_state != ST_LOAD, {1'b0, r_found} <= need)
    `KMST_ASSERT_NEXT(a_ready_after_run, out_accept && o_out_data.is_last, o_in_ready)

endmodule
